[rtl/core/sha1_pkg.sv]
// sha1_pkg: shared types, constants and helpers for the sha-1 digest core
// no dependencies; imported by sha1_msg_sched, sha1_round_unit and sha1_message_digest_core

package sha1_pkg;

    localparam int unsigned NUM_CHAIN   = 5;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUND_W     = 7;

    typedef logic [31:0] word_t;
    typedef word_t [NUM_CHAIN-1:0] chain_t;

    // initial chaining value
    localparam word_t CHAIN_IV [NUM_CHAIN] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // round constants, one per group of twenty rounds
    localparam word_t K_00_19 = 32'h5A827999;
    localparam word_t K_20_39 = 32'h6ED9EBA1;
    localparam word_t K_40_59 = 32'h8F1BBCDC;
    localparam word_t K_60_79 = 32'hCA62C1D6;

    localparam logic [ROUND_W-1:0] ROUND_20   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_40   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_60   = 7'd60;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [2:0] LAST_INDEX = 3'd4;

    // command codes
    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    // controls for the block buffer / message schedule
    typedef struct packed {
        logic       wr_byte;
        logic [5:0] pos;
        logic [7:0] byte_val;
        logic       shift;
        logic       clear;
        logic       load_len;
    } sched_ctrl_t;

    // controls for the round unit
    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic init;
    } round_ctrl_t;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

endpackage

[rtl/core/sha1_in_if.sv]
// sha1_in_if: message input channel, one command or byte per beat
// no dependencies

interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

[rtl/core/sha1_out_if.sv]
// sha1_out_if: digest output channel, one 32-bit digest word per beat
// no dependencies

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        too_long;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, output too_long, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, input too_long, output ready);
endinterface

[rtl/core/sha1_msg_sched.sv]
// sha1_msg_sched: 16-word block buffer that doubles as the message schedule
// depends on sha1_pkg

module sha1_msg_sched
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sched_ctrl_t ctrl,
    input  logic [63:0] bit_len,
    output word_t       w
);

    word_t blk_reg  [BLOCK_WORDS];
    word_t blk_next [BLOCK_WORDS];

    // shift for rounds, clear after a block, byte insert, length insert
    always_comb
    begin
        blk_next = blk_reg;
        if (ctrl.shift)
        begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++)
            begin
                blk_next[k] = blk_reg[k+1];
            end
            blk_next[BLOCK_WORDS-1] =
                rotl(blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0], 1);
        end
        if (ctrl.clear)
        begin
            for (int k = 0; k < BLOCK_WORDS; k++)
            begin
                blk_next[k] = '0;
            end
        end
        if (ctrl.wr_byte)
        begin
            blk_next[ctrl.pos[5:2]] = blk_reg[ctrl.pos[5:2]]
                | ({24'b0, ctrl.byte_val} << {~ctrl.pos[1:0], 3'b000});
        end
        if (ctrl.load_len)
        begin
            blk_next[14] = bit_len[63:32];
            blk_next[15] = bit_len[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BLOCK_WORDS; k++)
            begin
                blk_reg[k] <= '0;
            end
        end
        else
        begin
            blk_reg <= blk_next;
        end
    end

    // current schedule word
    assign w = blk_reg[0];

endmodule

[rtl/core/sha1_round_unit.sv]
// sha1_round_unit: one shared sha-1 round, working variables and chaining words
// depends on sha1_pkg

module sha1_round_unit
    import sha1_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  round_ctrl_t        ctrl,
    input  logic [ROUND_W-1:0] round_idx,
    input  word_t              w,
    output chain_t             chain
);

    word_t  a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t  a_next, b_next, c_next, d_next, e_next;
    chain_t chain_reg, chain_next;
    word_t  f_val;
    word_t  k_val;
    word_t  t_val;

    // round function and constant by round group
    always_comb
    begin
        if (round_idx < ROUND_20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_00_19;
        end
        else if (round_idx < ROUND_40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_20_39;
        end
        else if (round_idx < ROUND_60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_40_59;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_60_79;
        end
        t_val = rotl(a_reg, 5) + f_val + e_reg + w + k_val;
    end

    // working variables
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (ctrl.load)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end
        else if (ctrl.step)
        begin
            a_next = t_val;
            b_next = a_reg;
            c_next = rotl(b_reg, 30);
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    // chaining words: fold after 80 rounds, back to iv after a digest
    always_comb
    begin
        chain_next = chain_reg;
        if (ctrl.init)
        begin
            for (int k = 0; k < NUM_CHAIN; k++)
            begin
                chain_next[k] = CHAIN_IV[k];
            end
        end
        else if (ctrl.fold)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHAIN; k++)
            begin
                chain_reg[k] <= CHAIN_IV[k];
            end
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

[rtl/core/sha1_message_digest_core.sv]
// sha1_message_digest_core: byte-serial sha-1 engine, one round per cycle.
// a data byte is accepted in idle; the byte that fills a block then runs
// load, the rounds on the shared round unit and fold. finish runs these steps
// (none after a length overflow), twice when padding spills into an extra
// block, then 5 digest beats. no byte is accepted outside idle.
// reset (async, active low) loads the iv, clears the buffer and the length.
// depends on sha1_pkg, sha1_in_if, sha1_out_if, sha1_msg_sched, sha1_round_unit

module sha1_message_digest_core
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sha1_in_if.sink     msg,
    sha1_out_if.source  digest
);

    state_t               state_reg, state_next;
    logic [ROUND_W-1:0]   round_cnt_reg, round_cnt_next;
    logic [5:0]           pos_reg, pos_next;
    logic [63:0]          bit_len_reg, bit_len_next;
    logic                 ovf_reg, ovf_next;
    logic                 len_pend_reg, len_pend_next;
    logic                 finish_reg, finish_next;
    logic [2:0]           word_idx_reg, word_idx_next;

    logic                 in_beat;
    logic                 out_beat;
    logic                 last_beat;
    logic [63:0]          len_sum;
    logic                 len_wrap;
    logic                 is_finish;
    logic                 pad_spill;
    sched_ctrl_t          sched_ctrl;
    round_ctrl_t          round_ctrl;
    word_t                sched_w;
    chain_t               chain;

    assign in_beat   = msg.valid && msg.ready;
    assign out_beat  = digest.valid && digest.ready;
    assign last_beat = out_beat && (word_idx_reg == LAST_INDEX);
    assign is_finish = (msg.command == CMD_FINISH);
    assign len_sum   = bit_len_reg + 64'd8;
    assign len_wrap  = (len_sum == '0);
    assign pad_spill = (pos_reg[5:3] == 3'b111);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (is_finish)
                    begin
                        state_next = ovf_reg ? ST_EMIT : ST_LOAD;
                    end
                    else if (!ovf_reg && (pos_reg == 6'd63) && !len_wrap)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (len_pend_reg)
                begin
                    state_next = ST_LOAD;
                end
                else if (finish_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (last_beat)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // per-state controls; ready is high throughout idle, so a valid beat there is accepted
    always_comb
    begin
        msg.ready           = 1'b0;
        digest.valid        = 1'b0;
        sched_ctrl          = '0;
        sched_ctrl.pos      = pos_reg;
        sched_ctrl.byte_val = is_finish ? PAD_BYTE : msg.data_byte;
        round_ctrl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                msg.ready           = 1'b1;
                sched_ctrl.wr_byte  = msg.valid && !ovf_reg;
                sched_ctrl.load_len = msg.valid && !ovf_reg && is_finish && !pad_spill;
            end
            ST_LOAD:
            begin
                round_ctrl.load = 1'b1;
            end
            ST_ROUND:
            begin
                sched_ctrl.shift = 1'b1;
                round_ctrl.step  = 1'b1;
            end
            ST_FOLD:
            begin
                sched_ctrl.clear    = 1'b1;
                sched_ctrl.load_len = len_pend_reg;
                round_ctrl.fold     = 1'b1;
            end
            ST_EMIT:
            begin
                digest.valid     = 1'b1;
                sched_ctrl.clear = last_beat;
                round_ctrl.init  = last_beat;
            end
            default:
            begin
                msg.ready = 1'b0;
            end
        endcase
    end

    // counters, length and flags
    always_comb
    begin
        round_cnt_next = round_cnt_reg;
        pos_next       = pos_reg;
        bit_len_next   = bit_len_reg;
        ovf_next       = ovf_reg;
        len_pend_next  = len_pend_reg;
        finish_next    = finish_reg;
        word_idx_next  = word_idx_reg;
        if ((state_reg == ST_IDLE) && in_beat && !ovf_reg)
        begin
            if (is_finish)
            begin
                finish_next   = 1'b1;
                len_pend_next = pad_spill;
            end
            else
            begin
                pos_next     = pos_reg + 6'd1;
                bit_len_next = len_sum;
                ovf_next     = len_wrap;
            end
        end
        if (state_reg == ST_ROUND)
        begin
            round_cnt_next = (round_cnt_reg == LAST_ROUND) ? '0 : round_cnt_reg + 7'd1;
        end
        if (state_reg == ST_FOLD)
        begin
            len_pend_next = 1'b0;
        end
        if ((state_reg == ST_EMIT) && out_beat)
        begin
            word_idx_next = word_idx_reg + 3'd1;
        end
        if (last_beat)
        begin
            word_idx_next = '0;
            pos_next      = '0;
            bit_len_next  = '0;
            ovf_next      = 1'b0;
            finish_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_cnt_reg <= '0;
            pos_reg       <= '0;
            bit_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            len_pend_reg  <= 1'b0;
            finish_reg    <= 1'b0;
            word_idx_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
            pos_reg       <= pos_next;
            bit_len_reg   <= bit_len_next;
            ovf_reg       <= ovf_next;
            len_pend_reg  <= len_pend_next;
            finish_reg    <= finish_next;
            word_idx_reg  <= word_idx_next;
        end
    end

    sha1_msg_sched u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sched_ctrl),
        .bit_len (bit_len_reg),
        .w       (sched_w)
    );

    sha1_round_unit u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (round_ctrl),
        .round_idx (round_cnt_reg),
        .w         (sched_w),
        .chain     (chain)
    );

    // digest beat payload straight from the chaining registers, zero when the length overflowed
    assign digest.digest_word = ovf_reg ? '0 : chain[word_idx_reg];
    assign digest.word_index  = word_idx_reg;
    assign digest.last_word   = (word_idx_reg == LAST_INDEX);
    assign digest.too_long    = ovf_reg;

    // round counter stays within the 80 rounds
    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_cnt_reg <= LAST_ROUND))
        else $error("round counter out of range");

    // every block starts at round zero
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> ((state_reg == ST_ROUND) && (round_cnt_reg == '0)))
        else $error("round sequence did not start at zero");

    // digest beats only carry word positions 0..4
    a_word_idx: assert property (@(posedge clk) disable iff (!rst_n)
        digest.valid |-> (word_idx_reg <= LAST_INDEX))
        else $error("digest word index out of range");

    // after the final digest beat the engine is back in its initial state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        last_beat |=> ((state_reg == ST_IDLE) && (bit_len_reg == '0) && !ovf_reg
                       && (pos_reg == '0)))
        else $error("engine not reset after digest");

    // length overflow flag holds until the digest is delivered
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && !last_beat) |=> ovf_reg)
        else $error("overflow flag dropped early");

endmodule
